// ===== rtl/priority_task_dispatcher_core_macros.svh =====
// Assertion macros shared by the dispatcher RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef PRIORITY_TASK_DISPATCHER_CORE_MACROS_SVH
`define PRIORITY_TASK_DISPATCHER_CORE_MACROS_SVH

// same-cycle implication
`define PTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptd_pkg.sv =====
// Types shared by the priority task dispatcher modules.
// No dependencies.
package ptd_pkg;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [7:0]  priority_req;
        logic [15:0] run_ticks;
    } entry_t;

    typedef struct packed {
        logic   insert;
        logic   pop;
        entry_t new_entry;
    } cell_cmd_t;

endpackage

// ===== rtl/ptd_cell.sv =====
// One slot of the sorted task queue.
// Depends on ptd_pkg.
module ptd_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic              clk,
    input  ptd_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]     count,
    input  ptd_pkg::entry_t   prev_entry,
    input  logic              prev_gt,
    input  ptd_pkg::entry_t   next_entry,
    output ptd_pkg::entry_t   entry,
    output logic              gt
);

    ptd_pkg::entry_t entry_reg;
    ptd_pkg::entry_t entry_next;
    logic            valid;

    assign valid = (count > CW'(IDX));
    assign gt    = !valid || (cmd.new_entry.priority_req > entry_reg.priority_req);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.insert)
        begin
            if (prev_gt)
            begin
                entry_next = prev_entry;
            end
            else if (gt)
            begin
                entry_next = cmd.new_entry;
            end
        end
        else if (cmd.pop)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/ptd_queue.sv =====
// Priority queue built as a chain of ptd_cell slots plus the fill count.
// Depends on ptd_pkg and ptd_cell.
module ptd_queue #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ptd_pkg::cell_cmd_t cmd,
    output ptd_pkg::entry_t    head,
    output logic [CW-1:0]      count,
    output logic [CW-1:0]      count_after
);

    ptd_pkg::entry_t ent [DEPTH];
    logic            gt  [DEPTH];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ptd_pkg::entry_t p_entry;
        ptd_pkg::entry_t n_entry;
        logic            p_gt;

        if (i == 0)
        begin : g_first
            assign p_entry = ent[0];
            assign p_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign p_entry = ent[i-1];
            assign p_gt    = gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign n_entry = ent[i];
        end
        else
        begin : g_inner
            assign n_entry = ent[i+1];
        end

        ptd_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .prev_entry (p_entry),
            .prev_gt    (p_gt),
            .next_entry (n_entry),
            .entry      (ent[i]),
            .gt         (gt[i])
        );
    end

    assign head        = ent[0];
    assign count       = count_reg;
    assign count_after = count_next;

endmodule

// ===== rtl/priority_task_dispatcher_core.sv =====
// Priority task dispatcher: input stream, sorted queue, one processing station.
// Depends on ptd_pkg, ptd_queue and priority_task_dispatcher_core_macros.svh.
//
// Usage: each input item on s_* is either a tick (s_tuser = 0) or a task
// arrival (s_tuser = 1) with id, priority and processing time in s_tdata.
// Every accepted item yields exactly one result item on m_*, reporting a
// dispatch (if the tick moved a task into the station), the queue fill after
// the item, running dispatch and tick counters, and a drop flag for arrivals
// that met a full queue. Tasks wait in a chain of QUEUE_DEPTH cells kept
// sorted by priority, equal priorities in arrival order; an arrival shifts
// the lower cells down, a dispatch shifts all cells up.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while m_tready allows, set by the insert or pop of the cell chain.
// The result sits in an output register; a new item is taken in the same
// cycle the waiting result is taken. While m_tready is low the result holds
// and s_tready stays low. Reset empties the queue, idles the station and
// clears both counters; no clearing pass is needed.
`include "priority_task_dispatcher_core_macros.svh"

module priority_task_dispatcher_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // task_id[7:0], priority_req[15:8], run_ticks[31:16]
    input  logic        s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // out_task_id[7:0], out_priority[15:8],
                                   // out_proc_time[31:16], waiting_count[36:32],
                                   // dispatch_total[52:37], tick_number[84:53], zero
    output logic [1:0]  m_tuser    // dispatched[0], dropped[1]
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ptd_pkg::cell_cmd_t cmd;
    ptd_pkg::entry_t    head;
    ptd_pkg::entry_t    in_entry;
    logic [CW-1:0]      q_count;
    logic [CW-1:0]      q_count_after;

    logic               accept;
    logic               is_arrival;
    logic               q_full;
    logic               do_dispatch;
    logic [15:0]        elapsed_inc;

    logic               busy_reg,     busy_next;
    logic [15:0]        proc_reg,     proc_next;
    logic [15:0]        elapsed_reg,  elapsed_next;
    logic [31:0]        tick_reg,     tick_next;
    logic [15:0]        disp_cnt_reg, disp_cnt_next;

    logic               out_valid_reg;
    logic               dispatched_reg;
    logic               dropped_reg;
    ptd_pkg::entry_t    out_entry_reg;
    logic [4:0]         waiting_reg;
    logic [15:0]        total_reg;
    logic [31:0]        tick_out_reg;

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign is_arrival = s_tuser;
    assign in_entry   = {s_tdata[7:0], s_tdata[15:8], s_tdata[31:16]};
    assign q_full     = (q_count == CW'(QUEUE_DEPTH));
    assign do_dispatch = accept && !is_arrival && !busy_reg && (q_count != '0);
    assign elapsed_inc = elapsed_reg + 16'd1;

    assign cmd.insert    = accept && is_arrival && !q_full;
    assign cmd.pop       = do_dispatch;
    assign cmd.new_entry = in_entry;

    ptd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .head        (head),
        .count       (q_count),
        .count_after (q_count_after)
    );

    always_comb
    begin
        busy_next     = busy_reg;
        proc_next     = proc_reg;
        elapsed_next  = elapsed_reg;
        tick_next     = tick_reg;
        disp_cnt_next = disp_cnt_reg;
        if (accept && !is_arrival)
        begin
            tick_next = tick_reg + 32'd1;
            if (do_dispatch)
            begin
                busy_next     = 1'b1;
                proc_next     = head.run_ticks;
                elapsed_next  = '0;
                disp_cnt_next = disp_cnt_reg + 16'd1;
            end
            else if (busy_reg)
            begin
                if (elapsed_inc >= proc_reg)
                begin
                    busy_next    = 1'b0;
                    elapsed_next = '0;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            proc_reg      <= '0;
            elapsed_reg   <= '0;
            tick_reg      <= '0;
            disp_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            proc_reg     <= proc_next;
            elapsed_reg  <= elapsed_next;
            tick_reg     <= tick_next;
            disp_cnt_reg <= disp_cnt_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dispatched_reg <= do_dispatch;
            dropped_reg    <= is_arrival && q_full;
            out_entry_reg  <= do_dispatch ? head : '0;
            waiting_reg    <= 5'(q_count_after);
            total_reg      <= disp_cnt_next;
            tick_out_reg   <= tick_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {dropped_reg, dispatched_reg};
    assign m_tdata  = {3'b000, tick_out_reg, total_reg, waiting_reg,
                       out_entry_reg.run_ticks, out_entry_reg.priority_req,
                       out_entry_reg.task_id};

    `PTD_ASSERT_NOW(a_count_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH),
        "queue count above depth")
    `PTD_ASSERT_NEXT(a_full_drop, accept && is_arrival && q_full,
        out_valid_reg && dropped_reg && !dispatched_reg, "full-queue arrival not dropped")
    `PTD_ASSERT_NEXT(a_idle_dispatch, accept && !is_arrival && !busy_reg && q_count != '0,
        dispatched_reg && busy_reg, "idle tick with waiting tasks did not dispatch")
    `PTD_ASSERT_NOW(a_disp_busy, out_valid_reg && dispatched_reg, busy_reg,
        "dispatch reported while station idle")
    `PTD_ASSERT_NEXT(a_arrival_no_tick, accept && is_arrival, $stable(tick_reg),
        "arrival advanced the tick counter")

endmodule

// ===== tb/tb_priority_task_dispatcher_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for priority_task_dispatcher_core: a directed table, a long drain
// and random tick/arrival traffic with an in-bench priority queue predictor.
// Depends on ptd_pkg and the dispatcher RTL.
module tb_priority_task_dispatcher_core;

    localparam int   QUEUE_DEPTH   = 16;
    localparam int   QUIET_LIMIT   = 2000;
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_ARRIVAL  = 1'b1;

    typedef struct packed {
        logic        dispatched;
        logic [7:0]  out_task_id;
        logic [7:0]  out_priority;
        logic [15:0] out_proc_time;
        logic [4:0]  waiting_count;
        logic [15:0] dispatch_total;
        logic [31:0] tick_number;
        logic        dropped;
    } result_t;

    typedef struct {
        logic        kind;
        logic [7:0]  task_id;
        logic [7:0]  priority_req;
        logic [15:0] run_ticks;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;

    ptd_pkg::entry_t task_queue[$];
    logic        station_busy;
    logic [15:0] station_proc;
    logic [15:0] elapsed_ticks;
    logic [31:0] tick_count;
    logic [15:0] dispatch_count;

    result_t     pending_results[$];
    stim_row_t   directed_rows[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;

    priority_task_dispatcher_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t result_of(logic disp, logic [7:0] id, logic [7:0] pri,
                                          logic [15:0] proc, logic [4:0] waiting,
                                          logic [15:0] total, logic [31:0] tick, logic drop);
        result_t r;
        r.dispatched     = disp;
        r.out_task_id    = id;
        r.out_priority   = pri;
        r.out_proc_time  = proc;
        r.waiting_count  = waiting;
        r.dispatch_total = total;
        r.tick_number    = tick;
        r.dropped        = drop;
        return r;
    endfunction

    function automatic result_t dispatch_step(logic kind, logic [7:0] id, logic [7:0] pri,
                                              logic [15:0] proc);
        result_t r;
        int      best;
        r = '0;
        r.tick_number = tick_count;
        if (kind == KIND_ARRIVAL)
        begin
            if (task_queue.size() >= QUEUE_DEPTH)
                r.dropped = 1'b1;
            else
                task_queue.push_back({id, pri, proc});
        end
        else
        begin
            if (!station_busy)
            begin
                if (task_queue.size() > 0)
                begin
                    best = 0;
                    for (int i = 1; i < task_queue.size(); i++)
                        if (task_queue[i].priority_req > task_queue[best].priority_req)
                            best = i;
                    r.dispatched    = 1'b1;
                    r.out_task_id   = task_queue[best].task_id;
                    r.out_priority  = task_queue[best].priority_req;
                    r.out_proc_time = task_queue[best].run_ticks;
                    station_proc    = task_queue[best].run_ticks;
                    task_queue.delete(best);
                    station_busy    = 1'b1;
                    elapsed_ticks   = '0;
                    dispatch_count  = dispatch_count + 16'd1;
                end
            end
            else
            begin
                elapsed_ticks = elapsed_ticks + 16'd1;
                if (elapsed_ticks >= station_proc)
                begin
                    station_busy  = 1'b0;
                    elapsed_ticks = '0;
                end
            end
            tick_count = tick_count + 32'd1;
        end
        r.waiting_count  = 5'(task_queue.size());
        r.dispatch_total = dispatch_count;
        return r;
    endfunction

    task automatic add_row(logic kind, logic [7:0] id, logic [7:0] pri, logic [15:0] proc,
                           bit typed, result_t want);
        stim_row_t row;
        row.kind         = kind;
        row.task_id      = id;
        row.priority_req = pri;
        row.run_ticks    = proc;
        row.typed        = typed;
        row.want         = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(logic kind, logic [7:0] id, logic [7:0] pri, logic [15:0] proc,
                             bit typed, result_t typed_want);
        result_t predicted;
        predicted = dispatch_step(kind, id, pri, proc);
        pending_results.push_back(typed ? typed_want : predicted);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {proc, pri, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic void cmp_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always
    begin
        @(negedge clk);
        if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item expected none, got tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                cmp_field("dispatched", 64'(want.dispatched), 64'(m_tuser[0]));
                cmp_field("out_task_id", 64'(want.out_task_id), 64'(m_tdata[7:0]));
                cmp_field("out_priority", 64'(want.out_priority), 64'(m_tdata[15:8]));
                cmp_field("out_proc_time", 64'(want.out_proc_time), 64'(m_tdata[31:16]));
                cmp_field("waiting_count", 64'(want.waiting_count), 64'(m_tdata[36:32]));
                cmp_field("dispatch_total", 64'(want.dispatch_total), 64'(m_tdata[52:37]));
                cmp_field("tick_number", 64'(want.tick_number), 64'(m_tdata[84:53]));
                cmp_field("dropped", 64'(want.dropped), 64'(m_tuser[1]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          pct;
        logic        kind;
        logic [7:0]  id;
        logic [7:0]  pri;
        logic [15:0] proc;

        task_queue.delete();
        station_busy   = 1'b0;
        station_proc   = '0;
        elapsed_ticks  = '0;
        tick_count     = '0;
        dispatch_count = '0;

        add_row(KIND_TICK,    8'h00, 8'h00, 16'h0000, 1, result_of(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(KIND_ARRIVAL, 8'h00, 8'h00, 16'h0000, 1, result_of(0, 0, 0, 0, 1, 0, 1, 0));
        add_row(KIND_ARRIVAL, 8'hA5, 8'hFF, 16'h0000, 1, result_of(0, 0, 0, 0, 2, 0, 1, 0));
        add_row(KIND_ARRIVAL, 8'h5A, 8'hFF, 16'h0001, 1, result_of(0, 0, 0, 0, 3, 0, 1, 0));
        add_row(KIND_TICK,    8'hFF, 8'hFF, 16'hFFFF, 1,
                result_of(1, 8'hA5, 8'hFF, 16'h0000, 2, 1, 1, 0));
        add_row(KIND_TICK,    8'h00, 8'h00, 16'h0000, 1, result_of(0, 0, 0, 0, 2, 1, 2, 0));
        add_row(KIND_TICK,    8'h00, 8'h00, 16'h0000, 1,
                result_of(1, 8'h5A, 8'hFF, 16'h0001, 1, 2, 3, 0));
        add_row(KIND_ARRIVAL, 8'hC3, 8'h00, 16'h0020, 0, '0);
        add_row(KIND_ARRIVAL, 8'h01, 8'h80, 16'h0002, 0, '0);
        add_row(KIND_ARRIVAL, 8'h02, 8'h7F, 16'h0003, 0, '0);
        add_row(KIND_ARRIVAL, 8'h03, 8'h80, 16'h0001, 0, '0);
        add_row(KIND_ARRIVAL, 8'h04, 8'hFE, 16'h0002, 0, '0);
        add_row(KIND_ARRIVAL, 8'h05, 8'h01, 16'h0000, 0, '0);
        add_row(KIND_ARRIVAL, 8'h06, 8'hFE, 16'h0001, 0, '0);
        add_row(KIND_ARRIVAL, 8'h07, 8'h40, 16'h0004, 0, '0);
        add_row(KIND_ARRIVAL, 8'h08, 8'h10, 16'h0002, 0, '0);
        add_row(KIND_ARRIVAL, 8'h09, 8'hFE, 16'h0003, 0, '0);
        add_row(KIND_ARRIVAL, 8'h0A, 8'h20, 16'h0001, 0, '0);
        add_row(KIND_ARRIVAL, 8'h0B, 8'h55, 16'h0000, 0, '0);
        add_row(KIND_ARRIVAL, 8'h0C, 8'hAA, 16'h0002, 0, '0);
        add_row(KIND_ARRIVAL, 8'h0D, 8'hFF, 16'h0002, 0, '0);
        add_row(KIND_ARRIVAL, 8'h0E, 8'h00, 16'h0001, 0, '0);
        add_row(KIND_ARRIVAL, 8'h99, 8'hFF, 16'h1234, 1, result_of(0, 0, 0, 0, 16, 2, 4, 1));
        add_row(KIND_TICK,    8'h00, 8'h00, 16'h0000, 1, result_of(0, 0, 0, 0, 16, 2, 4, 0));
        add_row(KIND_TICK,    8'h00, 8'h00, 16'h0000, 0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].task_id,
                      directed_rows[i].priority_req, directed_rows[i].run_ticks,
                      directed_rows[i].typed, directed_rows[i].want);

        // hold off until all pending results are checked, then drain the queued tasks with ticks
        wait_for_results();
        while (task_queue.size() != 0 || station_busy)
            send_item(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 0, '0);

        for (int seg = 0; seg < 14; seg++)
        begin
            case ($urandom_range(0, 3))
                0: pct = 20;
                1: pct = 45;
                2: pct = 60;
                default: pct = 90;
            endcase
            gaps_on   = (seg < 11);
            stalls_on = (seg < 11);
            repeat (60)
            begin
                kind = ($urandom_range(0, 99) < pct) ? KIND_ARRIVAL : KIND_TICK;
                id   = 8'($urandom_range(0, 255));
                pri  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(0, 255));
                if (kind == KIND_TICK || task_queue.size() >= QUEUE_DEPTH)
                    proc = 16'($urandom_range(0, 65535));
                else if ($urandom_range(0, 7) == 0)
                    proc = 16'($urandom_range(0, 12));
                else
                    proc = 16'($urandom_range(0, 3));
                send_item(kind, id, pri, proc, 0, '0);
            end
            if (seg == 6)
                wait_for_results();
        end

        wait_for_results();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptd_pkg.sv
rtl/ptd_cell.sv
rtl/ptd_queue.sv
rtl/priority_task_dispatcher_core.sv
tb/tb_priority_task_dispatcher_core.sv
